// ===== design/mbdf_pkg.sv =====
// Shared types and constants for the mip box downsample fade unit.
// No dependencies; every other design file but mbdf_ram imports this package.
package mbdf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = IDX_W + 1;
  localparam int CNT_W      = COL_W + 1;

  localparam int LANES      = 4;
  localparam int BYTE_W     = 8;
  localparam int PAIR_W     = BYTE_W + 1;
  localparam int SUM_W      = BYTE_W + 2;
  localparam int PIX_W      = LANES * BYTE_W;
  localparam int LINE_W     = LANES * PAIR_W;
  localparam int V_W        = 18;
  localparam int IMG_W_W    = 12;
  localparam int WGT_W      = 9;
  localparam int FIFO_DEPTH = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_FADE_TARGET   = 3'd1,
    REG_BLEND_WEIGHT  = 3'd2,
    REG_COLOR_FADE_ON = 3'd3,
    REG_FADE_ALPHA_ON = 3'd4
  } reg_idx_e;

  typedef logic [LANES-1:0][PAIR_W-1:0] pair_t;
  typedef logic [LANES-1:0][SUM_W-1:0]  job_t;

  typedef struct packed {
    logic [PIX_W-1:0] fade_target;
    logic [WGT_W-1:0] blend_weight;
    logic             color_on;
    logic             alpha_on;
  } fade_cfg_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    pair_t            wdata;
  } line_req_t;

endpackage

// ===== design/mbdf_ram.sv =====
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module mbdf_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mbdf_fifo.sv =====
// Short word queue between the front and back parts.
// Depends on mbdf_pkg (job_t, FIFO_DEPTH).
module mbdf_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mbdf_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output mbdf_pkg::job_t data_o,
  output logic          empty_o
);
  import mbdf_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/mbdf_front.sv =====
// Front part: takes source pixels, tracks column/row, builds pair sums,
// drives the line store and hands 2x2 byte sums to the queue. Uses mbdf_pkg.
module mbdf_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mbdf_pkg::IMG_W_W-1:0]      image_width_i,
  input  logic                              accept_i,
  input  logic [mbdf_pkg::PIX_W-1:0]        pixel_in_i,
  input  logic                              frame_start_i,
  output mbdf_pkg::line_req_t               line_req_o,
  input  mbdf_pkg::pair_t                   line_rdata_i,
  output logic                              job_push_o,
  output mbdf_pkg::job_t                    job_o
);
  import mbdf_pkg::*;

  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic             odd_q, odd_d, odd_cur;
  logic [PIX_W-1:0] held_q, held_d;
  logic [31:0]      w_wide;
  logic [CNT_W-1:0] eff_w, col_nxt;
  pair_t            ps;

  // effective row length: even, at least two, at most MAX_WIDTH
  always_comb begin
    w_wide = {20'b0, image_width_i & 12'hFFE};
    if (w_wide < 32'd2) begin
      w_wide = 32'd2;
    end else if (w_wide > 32'(MAX_WIDTH)) begin
      w_wide = 32'(MAX_WIDTH) & ~32'd1;
    end
    eff_w = w_wide[CNT_W-1:0];
  end

  assign col_cur = frame_start_i ? '0 : col_q;
  assign odd_cur = frame_start_i ? 1'b0 : odd_q;
  assign col_nxt = {1'b0, col_cur} + CNT_W'(1);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ps[k] = {1'b0, held_q[k*BYTE_W +: BYTE_W]} + {1'b0, pixel_in_i[k*BYTE_W +: BYTE_W]};
    end
  end

  always_comb begin
    col_d            = col_q;
    odd_d            = odd_q;
    held_d           = held_q;
    line_req_o.we    = 1'b0;
    line_req_o.re    = 1'b0;
    line_req_o.addr  = col_cur[IDX_W:1];
    line_req_o.wdata = ps;
    job_push_o       = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      job_o[k] = {1'b0, ps[k]} + {1'b0, line_rdata_i[k]};
    end
    if (accept_i) begin
      if (!col_cur[0]) begin
        // left pixel of a pair; fetch the upper pair now, used on the right pixel
        held_d        = pixel_in_i;
        line_req_o.re = 1'b1;
      end else if (!odd_cur) begin
        line_req_o.we = 1'b1;
      end else begin
        job_push_o = 1'b1;
      end
      if (col_nxt >= eff_w) begin
        col_d = '0;
        odd_d = !odd_cur;
      end else begin
        col_d = col_nxt[COL_W-1:0];
        odd_d = odd_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      odd_q  <= 1'b0;
      held_q <= '0;
    end else begin
      col_q  <= col_d;
      odd_q  <= odd_d;
      held_q <= held_d;
    end
  end

endmodule

// ===== design/mbdf_back.sv =====
// Back part: two-stage fade/scale pipeline from 2x2 sums to output pixels,
// with the output word register. Uses mbdf_pkg.
module mbdf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mbdf_pkg::fade_cfg_t        cfg_i,
  input  logic                       job_valid_i,
  input  mbdf_pkg::job_t             job_i,
  output logic                       job_pop_o,
  output logic                       out_valid_o,
  output logic [mbdf_pkg::PIX_W-1:0] pixel_out_o,
  input  logic                       out_pop_i
);
  import mbdf_pkg::*;

  logic                        s1_v_q, s1_v_d;
  logic [LANES-1:0][V_W-1:0]   v_q, v_d;
  logic                        out_v_q, out_v_d;
  logic [PIX_W-1:0]            pix_q, pix_d;
  logic                        s1_adv, out_ld;
  logic [WGT_W-1:0]            wgt, inv;
  logic [BYTE_W-1:0]           fade_m [LANES];
  logic [18:0]                 p_src [LANES];
  logic [18:0]                 p_fade [LANES];
  logic [18:0]                 v_sum [LANES];
  logic [21:0]                 a9;
  logic [8:0]                  aq;

  assign out_ld    = !out_v_q || out_pop_i;
  assign s1_adv    = !s1_v_q || out_ld;
  assign job_pop_o = s1_adv && job_valid_i;

  assign wgt = (cfg_i.blend_weight > WGT_W'(256)) ? WGT_W'(256) : cfg_i.blend_weight;
  assign inv = WGT_W'(256) - wgt;

  // byte0..2 fade toward bits 23:16, 15:8, 7:0; alpha toward 31:24
  assign fade_m[0] = cfg_i.fade_target[23:16];
  assign fade_m[1] = cfg_i.fade_target[15:8];
  assign fade_m[2] = cfg_i.fade_target[7:0];
  assign fade_m[3] = cfg_i.fade_target[31:24];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      p_src[k]  = 19'(job_i[k]) * 19'(inv);
      p_fade[k] = (19'(fade_m[k]) * 19'(wgt)) << 2;
      v_sum[k]  = p_src[k] + p_fade[k];
      if ((k < 3) ? cfg_i.color_on : cfg_i.alpha_on) begin
        v_d[k] = v_sum[k][V_W-1:0];
      end else begin
        v_d[k] = {job_i[k], 8'b0};
      end
    end
    s1_v_d = s1_adv ? job_valid_i : s1_v_q;
  end

  // color bytes cannot exceed 255; alpha is 9/8 and saturates
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pix_d[k*BYTE_W +: BYTE_W] = v_q[k][V_W-1:10];
    end
    a9 = 22'({v_q[3], 3'b0}) + 22'(v_q[3]);
    aq = a9[21:13];
    pix_d[3*BYTE_W +: BYTE_W] = aq[8] ? 8'hFF : aq[7:0];
    out_v_d = out_ld ? s1_v_q : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      v_q <= v_d;
    end
    if (out_ld) begin
      pix_q <= pix_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign pixel_out_o = pix_q;

endmodule

// ===== design/mip_box_downsample_fade_unit.sv =====
// Top level of the mip box downsample fade unit: config registers, line store,
// front part, queue and back part. Depends on mbdf_pkg and all mbdf_* modules.
//
// Usage:
//  - Input channel: push/full. Source pixels in raster order, 32 bits each,
//    frame_start_i marks the first pixel of an image (column and row restart).
//  - Output channel: empty/pop. One word per 2x2 block, emitted when the right
//    pixel of each pair on an odd row is taken; other pixels give no word.
//  - Config port: cfg_we_i/cfg_idx_i/cfg_data_i, index 0 width, 1 fade color,
//    2 blend weight, 3 color fade enable, 4 alpha fade enable. Write only while
//    idle. Width is forced even and into 2..MAX_WIDTH; weight saturates at 256.
//  - Throughput: one pixel per clock while full is low; the front part then
//    takes a pixel every cycle. The line store is read on the left pixel and
//    written on the right one of an even row, never both in one cycle.
//  - Path: the word for a completed block passes the queue register, the blend
//    stage register and the output register before it shows on pixel_out_o.
//  - Stall: when pop is held low the back part fills, then the four-word queue
//    fills and full goes high; nothing is dropped.
//  - Reset: counters, row flag, queue and pipeline valids clear; registers go
//    to defaults (width 2, rest zero). The line store is not cleared; it is
//    always written on an even row before an odd row reads it.
module mip_box_downsample_fade_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mbdf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mbdf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic [mbdf_pkg::PIX_W-1:0]          pixel_in_i,
  input  logic                                frame_start_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [mbdf_pkg::PIX_W-1:0]          pixel_out_o
);
  import mbdf_pkg::*;

  logic [IMG_W_W-1:0] width_q;
  fade_cfg_t          cfg_q;
  logic               accept;
  line_req_t          line_req;
  pair_t              line_rdata;
  logic [LINE_W-1:0]  ram_rdata;
  logic               job_push, job_pop, q_full, q_empty, out_valid;
  job_t               job_in, job_out;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= IMG_W_W'(2);
      cfg_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:   width_q            <= cfg_data_i[IMG_W_W-1:0];
        REG_FADE_TARGET:   cfg_q.fade_target  <= cfg_data_i[PIX_W-1:0];
        REG_BLEND_WEIGHT:  cfg_q.blend_weight <= cfg_data_i[WGT_W-1:0];
        REG_COLOR_FADE_ON: cfg_q.color_on     <= cfg_data_i[0];
        REG_FADE_ALPHA_ON: cfg_q.alpha_on     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !full;

  mbdf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .image_width_i (width_q),
    .accept_i      (accept),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .line_req_o    (line_req),
    .line_rdata_i  (line_rdata),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  mbdf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_req.we),
    .waddr_i (line_req.addr),
    .wdata_i (line_req.wdata),
    .re_i    (line_req.re),
    .raddr_i (line_req.addr),
    .rdata_o (ram_rdata)
  );

  assign line_rdata = ram_rdata;

  mbdf_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (q_empty)
  );

  mbdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (!q_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid),
    .pixel_out_o (pixel_out_o),
    .out_pop_i   (pop)
  );

  assign empty = !out_valid;

  // a block word is only produced for an accepted pixel and never into a full queue
  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> (accept && !q_full))
    else $error("block word pushed without room or without an accepted pixel");

  // the line store port is never asked for a read and a write together
  a_line_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(line_req.we && line_req.re))
    else $error("line store read and write in the same cycle");

  // a queued word is handed over only when the queue holds one
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !q_empty)
    else $error("back part took a word from an empty queue");

  // a waiting result that is not taken stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !pop) |=> (out_valid && $stable(pixel_out_o)))
    else $error("output word changed while stalled");

endmodule
